// ----- hdl/fcbb_pkg.sv -----
// Package for the frame change bounding box block: shared widths, register
// indexes, beat and result types, and the dimension clamp.
// No dependencies.
package fcbb_pkg;

    // Largest frame dimension in pixels, and the widths that follow from it
    localparam int MAX_DIM = 4096;
    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = IDX_W + 1;

    // Pixel and configuration port widths
    localparam int PIX_W      = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // Stream data widths, padded to whole bytes
    localparam int IN_DATA_W  = 2 * PIX_W;
    localparam int RES_BITS   = 4 * DIM_W;
    localparam int OUT_DATA_W = ((RES_BITS + 7) / 8) * 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    // Reset values of the frame dimension registers
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH  = 13'd640;
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = 13'd480;

    // One input beat: a pixel of the new frame and the one it replaces
    typedef struct packed {
        logic [PIX_W-1:0] old_pixel;
        logic [PIX_W-1:0] new_pixel;
    } beat_t;

    // Clamped frame dimensions
    typedef struct packed {
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] width;
    } dims_t;

    // One result beat
    typedef struct packed {
        logic             any_change;
        logic [DIM_W-1:0] bottom;
        logic [DIM_W-1:0] right;
        logic [DIM_W-1:0] top;
        logic [DIM_W-1:0] left;
    } result_t;

    // Map zero to one and anything above the maximum to the maximum
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (DIM_W'(v) > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else
            r = DIM_W'(v);
        return r;
    endfunction

endpackage

// ----- hdl/fcbb_input_stage.sv -----
// Input register of the frame change bounding box block: holds one pixel
// pair beat until the tracker takes it.
// Depends on fcbb_pkg.
module fcbb_input_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_valid,
    output logic           s_ready,
    input  fcbb_pkg::beat_t s_beat,
    output logic           beat_valid,
    output fcbb_pkg::beat_t beat,
    input  logic           take
);

    logic            valid_reg;
    logic            valid_next;
    fcbb_pkg::beat_t beat_reg;

    // Accept a new beat when empty or when the held one leaves this cycle
    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Load payload on accept
    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
            beat_reg <= s_beat;
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

// ----- hdl/fcbb_tracker.sv -----
// Position counters, bounding box accumulation and result register of the
// frame change bounding box block.
// Depends on fcbb_pkg.
module fcbb_tracker
(
    input  logic              clk,
    input  logic              rst_n,
    input  fcbb_pkg::dims_t   dims,
    input  logic              beat_valid,
    input  fcbb_pkg::beat_t   beat,
    output logic              take,
    output logic              res_valid,
    input  logic              res_ready,
    output fcbb_pkg::result_t result
);

    localparam int IW = fcbb_pkg::IDX_W;
    localparam int DW = fcbb_pkg::DIM_W;

    logic [IW-1:0] col_reg, col_next;
    logic [IW-1:0] row_reg, row_next;
    logic [IW-1:0] min_col_reg, min_col_next;
    logic [IW-1:0] max_col_reg, max_col_next;
    logic [IW-1:0] min_row_reg, min_row_next;
    logic [IW-1:0] max_row_reg, max_row_next;
    logic          seen_reg, seen_next;
    logic          out_valid_reg, out_valid_next;
    fcbb_pkg::result_t result_reg, result_next;

    logic          diff;
    logic          last_col;
    logic          last_row;
    logic          frame_end;
    logic          emit;
    logic [IW-1:0] min_col_upd, max_col_upd, min_row_upd, max_row_upd;
    logic          seen_upd;

    // Position of the held beat within the frame
    assign diff      = beat.new_pixel != beat.old_pixel;
    assign last_col  = ({1'b0, col_reg} + DW'(1)) >= dims.width;
    assign last_row  = ({1'b0, row_reg} + DW'(1)) >= dims.height;
    assign frame_end = last_col && last_row;

    // Take the beat unless it ends a frame and the result slot is blocked
    assign take = beat_valid && (!frame_end || !out_valid_reg || res_ready);
    assign emit = take && frame_end;

    // Widen the box by the current position when the pixel changed
    always_comb
    begin
        min_col_upd = min_col_reg;
        max_col_upd = max_col_reg;
        min_row_upd = min_row_reg;
        max_row_upd = max_row_reg;
        seen_upd    = seen_reg;
        if (diff)
        begin
            if (col_reg < min_col_reg) min_col_upd = col_reg;
            if (col_reg > max_col_reg) max_col_upd = col_reg;
            if (row_reg < min_row_reg) min_row_upd = row_reg;
            if (row_reg > max_row_reg) max_row_upd = row_reg;
            seen_upd = 1'b1;
        end
    end

    // Advance counters, clear the box at frame end
    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        min_col_next = min_col_reg;
        max_col_next = max_col_reg;
        min_row_next = min_row_reg;
        max_row_next = max_row_reg;
        seen_next    = seen_reg;
        if (take)
        begin
            min_col_next = min_col_upd;
            max_col_next = max_col_upd;
            min_row_next = min_row_upd;
            max_row_next = max_row_upd;
            seen_next    = seen_upd;
            priority if (!last_col)
            begin
                col_next = col_reg + IW'(1);
            end
            else if (!last_row)
            begin
                col_next = '0;
                row_next = row_reg + IW'(1);
            end
            else
            begin
                col_next     = '0;
                row_next     = '0;
                min_col_next = '1;
                max_col_next = '0;
                min_row_next = '1;
                max_row_next = '0;
                seen_next    = 1'b0;
            end
        end
    end

    // Build the result from the updated box, zeros for an unchanged frame
    always_comb
    begin
        result_next = '0;
        if (seen_upd)
        begin
            result_next.left       = {1'b0, min_col_upd};
            result_next.top        = {1'b0, min_row_upd};
            result_next.right      = {1'b0, max_col_upd} + DW'(1);
            result_next.bottom     = {1'b0, max_row_upd} + DW'(1);
            result_next.any_change = 1'b1;
        end
    end

    // Hold the result until taken
    assign out_valid_next = emit || (out_valid_reg && !res_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            min_col_reg   <= '1;
            max_col_reg   <= '0;
            min_row_reg   <= '1;
            max_row_reg   <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            min_col_reg   <= min_col_next;
            max_col_reg   <= max_col_next;
            min_row_reg   <= min_row_next;
            max_row_reg   <= max_row_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            result_reg <= result_next;
    end

    assign res_valid = out_valid_reg;
    assign result    = result_reg;

    // A fresh result leaves the counters at the frame origin
    a_origin_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (col_reg == '0 && row_reg == '0))
        else $error("counters not cleared after frame end");

    // No change seen means the box is still empty
    a_empty_box: assert property (@(posedge clk) disable iff (!rst_n)
        !seen_reg |-> (min_col_reg == '1 && max_col_reg == '0 &&
                       min_row_reg == '1 && max_row_reg == '0))
        else $error("box widened without a change");

    // A changed frame gives a non-empty rectangle
    a_nonempty_rect: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.any_change) |->
            (result_reg.right > result_reg.left && result_reg.bottom > result_reg.top))
        else $error("empty rectangle for a changed frame");

    // An unchanged frame gives all zeros
    a_zero_rect: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_reg.any_change) |->
            (result_reg.left == '0 && result_reg.top == '0 &&
             result_reg.right == '0 && result_reg.bottom == '0))
        else $error("nonzero rectangle for an unchanged frame");

endmodule

// ----- hdl/frame_change_bounding_box_core.sv -----
// Top level of the frame change bounding box block: configuration registers,
// input register and tracker.
// Depends on fcbb_pkg, fcbb_input_stage and fcbb_tracker.
//
// Usage:
//   Stream pixel pairs (new frame, previous frame) on the s_ channel in
//   raster order, one beat per pixel. After the last pixel of each frame
//   (column frame_width-1 of row frame_height-1) one beat comes out on the
//   m_ channel: the half-open rectangle of changed pixels, or all zeros with
//   any_change low when the frame did not change.
//   Frame width and height are written through cfg_we/cfg_index/cfg_data;
//   zero counts as one and anything above 4096 as 4096. Write them between
//   frames.
// Timing:
//   One beat per cycle sustained unless a result waits on m_tready. A beat is
//   registered at the input and folded into the box when the tracker takes it;
//   the result is registered when the last beat of its frame is taken.
// Reset and stall:
//   Reset sets width 640, height 480 and starts a new frame at the origin.
//   While a result waits on m_tready, beats inside a frame keep flowing; only
//   the beat that closes the next frame waits in the input register, and
//   s_tready drops once that register is held.
module frame_change_bounding_box_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [fcbb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fcbb_pkg::CFG_DATA_W-1:0]     cfg_data,
    // pixel pair beats
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [fcbb_pkg::IN_DATA_W-1:0]      s_tdata,   // new_pixel, old_pixel
    // result beats
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fcbb_pkg::OUT_DATA_W-1:0]     m_tdata,   // left, top, right, bottom, zero pad
    output logic                                m_tuser    // any_change
);

    logic [fcbb_pkg::CFG_DATA_W-1:0] width_reg;
    logic [fcbb_pkg::CFG_DATA_W-1:0] height_reg;
    fcbb_pkg::dims_t                 dims;
    fcbb_pkg::beat_t                 s_beat;
    fcbb_pkg::beat_t                 beat;
    logic                            beat_valid;
    logic                            take;
    fcbb_pkg::result_t               result;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= fcbb_pkg::RST_FRAME_WIDTH;
            height_reg <= fcbb_pkg::RST_FRAME_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fcbb_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                fcbb_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign dims.width  = fcbb_pkg::clamp_dim(width_reg);
    assign dims.height = fcbb_pkg::clamp_dim(height_reg);

    // Unpack the input beat
    assign s_beat.new_pixel = s_tdata[fcbb_pkg::PIX_W-1:0];
    assign s_beat.old_pixel = s_tdata[fcbb_pkg::IN_DATA_W-1:fcbb_pkg::PIX_W];

    fcbb_input_stage u_input
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_beat     (s_beat),
        .beat_valid (beat_valid),
        .beat       (beat),
        .take       (take)
    );

    fcbb_tracker u_tracker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .dims       (dims),
        .beat_valid (beat_valid),
        .beat       (beat),
        .take       (take),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .result     (result)
    );

    // Pack the result beat
    assign m_tdata = {(fcbb_pkg::OUT_DATA_W - fcbb_pkg::RES_BITS)'(0),
                      result.bottom, result.right, result.top, result.left};
    assign m_tuser = result.any_change;

endmodule
